### design/wfsd_pkg.sv
// ----------------------------------------------------------------------------
// wfsd_pkg
// Shared types and constants for the window filter / sort / dedup block.
// ----------------------------------------------------------------------------
`default_nettype none

package wfsd_pkg;

  localparam int POINT_W   = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'b1;

  localparam logic [POINT_W-1:0] WINDOW_START_RST = 16'h0000;
  localparam logic [POINT_W-1:0] WINDOW_END_RST   = 16'hFFFF;

  // list select: bank of the shared list memory
  localparam logic LIST_END   = 1'b0;
  localparam logic LIST_START = 1'b1;

  typedef logic [POINT_W-1:0] point_t;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;      // stored entry equals candidate
    logic ahead;   // stored entry sorts ahead of candidate
  } cmp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIST,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_NEXT,
    S_OUT_INIT,
    S_OUT_RD_E,
    S_OUT_RD_S,
    S_OUT_EMIT
  } state_t;

endpackage

`default_nettype wire

### design/wfsd_ram.sv
// ----------------------------------------------------------------------------
// wfsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/wfsd_cmp.sv
// ----------------------------------------------------------------------------
// wfsd_cmp
// Shared compare unit: orders a stored list entry against a candidate point.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsd_cmp (
  input  wire logic            asc,
  input  wire wfsd_pkg::point_t entry,
  input  wire wfsd_pkg::point_t cand,
  output wfsd_pkg::cmp_t        res
);

  import wfsd_pkg::*;

  // ascending list: smaller entries come first; descending: larger ones
  always_comb begin
    res.eq    = (entry == cand);
    res.ahead = asc ? (entry < cand) : (entry > cand);
  end

endmodule

`default_nettype wire

### design/window_filter_sort_dedup.sv
// ----------------------------------------------------------------------------
// window_filter_sort_dedup
// Window filter with sorted, duplicate-free insertion into two lists and a
// side-by-side readout after the last pair of a set.
// ----------------------------------------------------------------------------
// Per pair, each kept point scans its list entry by entry, then a new point
//   shifts the entries behind its place up by one and is written in; a marked
//   last pair then reads out both lists side by side, results strobed one at
//   a time.
// Pairs are taken one at a time, the next one transfers in the idle cycle
//   after busy drops; the single read port of the shared list memory and the
//   one shared comparator set the pace.
// Reset (synchronous, rst_n low): window opens to [0, 65535], counts, overflow
//   and sequencer clear; list memory keeps its contents and needs no sweep.
// Results cannot be stalled: each one shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module window_filter_sort_dedup #(
  parameter int DEPTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [wfsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wfsd_pkg::POINT_W-1:0]      cfg_wdata,
  // input items
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [wfsd_pkg::POINT_W-1:0]      in_right_point,
  input  wire logic [wfsd_pkg::POINT_W-1:0]      in_left_point,
  input  wire logic                              in_last_pair,
  // results
  output logic                                   out_valid,
  output logic [wfsd_pkg::POINT_W-1:0]           out_end_point,
  output logic                                   out_end_valid,
  output logic [wfsd_pkg::POINT_W-1:0]           out_start_point,
  output logic                                   out_start_valid,
  output logic                                   out_overflow,
  output logic                                   out_last_result
);

  import wfsd_pkg::*;

  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  point_t win_start_r, win_end_r;

  point_t right_r, right_nxt;
  point_t left_r, left_nxt;
  logic   last_r, last_nxt;
  logic   keep_end_r, keep_end_nxt;
  logic   keep_start_r, keep_start_nxt;
  logic   sel_r, sel_nxt;

  logic [CNT_W-1:0] end_cnt_r, end_cnt_nxt;
  logic [CNT_W-1:0] start_cnt_r, start_cnt_nxt;
  logic [CNT_W-1:0] pairs_r, pairs_nxt;
  logic             ovf_r, ovf_nxt;

  logic [CNT_W-1:0] i_r, i_nxt;      // scan index
  logic [CNT_W-1:0] pos_r, pos_nxt;  // insert position
  logic             dup_r, dup_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;      // shift index
  logic [CNT_W-1:0] k_r, k_nxt;      // output index
  logic [CNT_W-1:0] runs_r, runs_nxt;
  point_t           edata_r, edata_nxt;

  logic   out_valid_r, out_valid_nxt;
  point_t out_end_point_r, out_end_point_nxt;
  logic   out_end_valid_r, out_end_valid_nxt;
  point_t out_start_point_r, out_start_point_nxt;
  logic   out_start_valid_r, out_start_valid_nxt;
  logic   out_overflow_r, out_overflow_nxt;
  logic   out_last_r, out_last_nxt;

  // --------------------------------------------------------------------------
  // Shared list memory (end list in the lower bank, start list in the upper)
  // and shared compare unit
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  point_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  point_t            ram_rdata;

  wfsd_ram #(
    .WIDTH (POINT_W),
    .DEPTH (RAM_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  point_t           cur_v;
  logic [CNT_W-1:0] cur_n;
  logic             cur_keep;
  logic             cur_asc;
  cmp_t             cmp_res;
  logic [CNT_W-1:0] j_dec;
  logic [CNT_W-1:0] k_inc;
  logic [CNT_W-1:0] runs_calc;
  logic             accept;
  logic             set_full;

  assign cur_v    = (sel_r == LIST_START) ? left_r : right_r;
  assign cur_n    = (sel_r == LIST_START) ? start_cnt_r : end_cnt_r;
  assign cur_keep = (sel_r == LIST_START) ? keep_start_r : keep_end_r;
  assign cur_asc  = (sel_r == LIST_END);
  assign j_dec    = j_r - ONE_C;
  assign k_inc    = k_r + ONE_C;
  assign accept   = start && (state_r == S_IDLE);
  assign set_full = (pairs_r >= DEPTH_C);

  always_comb begin
    runs_calc = (end_cnt_r > start_cnt_r) ? end_cnt_r : start_cnt_r;
    if (runs_calc == '0) begin
      runs_calc = ONE_C;
    end
  end

  wfsd_cmp u_cmp (
    .asc   (cur_asc),
    .entry (ram_rdata),
    .cand  (cur_v),
    .res   (cmp_res)
  );

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= WINDOW_START_RST;
      win_end_r   <= WINDOW_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_START: win_start_r <= cfg_wdata;
        REG_WINDOW_END:   win_end_r   <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!set_full) begin
            state_nxt = S_LIST;
          end else if (in_last_pair) begin
            state_nxt = S_OUT_INIT;
          end
        end
      end
      S_LIST:     state_nxt = cur_keep ? S_SCAN_RD : S_NEXT;
      S_SCAN_RD:  state_nxt = (i_r == cur_n) ? S_PLACE : S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = S_SCAN_RD;
      S_PLACE:    state_nxt = (dup_r || cur_n >= DEPTH_C) ? S_NEXT : S_SHIFT_RD;
      S_SHIFT_RD: state_nxt = (j_r == pos_r) ? S_INSERT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_INSERT:   state_nxt = S_NEXT;
      S_NEXT: begin
        if (sel_r == LIST_END) begin
          state_nxt = S_LIST;
        end else if (last_r) begin
          state_nxt = S_OUT_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT_INIT: state_nxt = S_OUT_RD_E;
      S_OUT_RD_E: state_nxt = S_OUT_RD_S;
      S_OUT_RD_S: state_nxt = S_OUT_EMIT;
      S_OUT_EMIT: state_nxt = (k_inc == runs_r) ? S_IDLE : S_OUT_RD_E;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath controls and register updates
  // --------------------------------------------------------------------------
  always_comb begin
    right_nxt           = right_r;
    left_nxt            = left_r;
    last_nxt            = last_r;
    keep_end_nxt        = keep_end_r;
    keep_start_nxt      = keep_start_r;
    sel_nxt             = sel_r;
    end_cnt_nxt         = end_cnt_r;
    start_cnt_nxt       = start_cnt_r;
    pairs_nxt           = pairs_r;
    ovf_nxt             = ovf_r;
    i_nxt               = i_r;
    pos_nxt             = pos_r;
    dup_nxt             = dup_r;
    j_nxt               = j_r;
    k_nxt               = k_r;
    runs_nxt            = runs_r;
    edata_nxt           = edata_r;
    out_valid_nxt       = 1'b0;
    out_end_point_nxt   = out_end_point_r;
    out_end_valid_nxt   = out_end_valid_r;
    out_start_point_nxt = out_start_point_r;
    out_start_valid_nxt = out_start_valid_r;
    out_overflow_nxt    = out_overflow_r;
    out_last_nxt        = out_last_r;
    ram_we              = 1'b0;
    ram_waddr           = '0;
    ram_wdata           = '0;
    ram_raddr           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // latch the pair and the window verdicts; a pair beyond capacity is
          // not inserted: it raises overflow and, if marked last, starts the readout
          right_nxt      = in_right_point;
          left_nxt       = in_left_point;
          last_nxt       = in_last_pair;
          keep_end_nxt   = (in_right_point >= win_start_r) &&
                           (in_right_point <= win_end_r);
          keep_start_nxt = (in_left_point >= win_start_r) &&
                           (in_left_point <= win_end_r);
          sel_nxt        = LIST_END;
          if (set_full) begin
            ovf_nxt = 1'b1;
          end else begin
            pairs_nxt = pairs_r + ONE_C;
          end
        end
      end
      S_LIST: begin
        i_nxt   = '0;
        pos_nxt = '0;
        dup_nxt = 1'b0;
      end
      S_SCAN_RD: begin
        ram_raddr = {sel_r, i_r[IDX_W-1:0]};
      end
      S_SCAN_CMP: begin
        // count entries that sort ahead; flag an equal entry
        if (cmp_res.eq) begin
          dup_nxt = 1'b1;
        end
        if (cmp_res.ahead) begin
          pos_nxt = pos_r + ONE_C;
        end
        i_nxt = i_r + ONE_C;
      end
      S_PLACE: begin
        j_nxt = cur_n;
      end
      S_SHIFT_RD: begin
        ram_raddr = {sel_r, j_dec[IDX_W-1:0]};
      end
      S_SHIFT_WR: begin
        // move entry j-1 up to j
        ram_we    = 1'b1;
        ram_waddr = {sel_r, j_r[IDX_W-1:0]};
        ram_wdata = ram_rdata;
        j_nxt     = j_dec;
      end
      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = {sel_r, pos_r[IDX_W-1:0]};
        ram_wdata = cur_v;
        if (sel_r == LIST_START) begin
          start_cnt_nxt = start_cnt_r + ONE_C;
        end else begin
          end_cnt_nxt = end_cnt_r + ONE_C;
        end
      end
      S_NEXT: begin
        if (sel_r == LIST_END) begin
          sel_nxt = LIST_START;
        end
      end
      S_OUT_INIT: begin
        runs_nxt = runs_calc;
        k_nxt    = '0;
      end
      S_OUT_RD_E: begin
        ram_raddr = {LIST_END, k_r[IDX_W-1:0]};
      end
      S_OUT_RD_S: begin
        ram_raddr = {LIST_START, k_r[IDX_W-1:0]};
        edata_nxt = ram_rdata;
      end
      S_OUT_EMIT: begin
        // drive one result; past the end of a list its fields read zero
        out_valid_nxt       = 1'b1;
        out_end_valid_nxt   = (k_r < end_cnt_r);
        out_end_point_nxt   = (k_r < end_cnt_r) ? edata_r : '0;
        out_start_valid_nxt = (k_r < start_cnt_r);
        out_start_point_nxt = (k_r < start_cnt_r) ? ram_rdata : '0;
        out_overflow_nxt    = ovf_r;
        out_last_nxt        = (k_inc == runs_r);
        k_nxt               = k_inc;
        if (k_inc == runs_r) begin
          // drop the set
          end_cnt_nxt   = '0;
          start_cnt_nxt = '0;
          pairs_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      end_cnt_r   <= '0;
      start_cnt_r <= '0;
      pairs_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      end_cnt_r   <= end_cnt_nxt;
      start_cnt_r <= start_cnt_nxt;
      pairs_r     <= pairs_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    right_r           <= right_nxt;
    left_r            <= left_nxt;
    last_r            <= last_nxt;
    keep_end_r        <= keep_end_nxt;
    keep_start_r      <= keep_start_nxt;
    sel_r             <= sel_nxt;
    i_r               <= i_nxt;
    pos_r             <= pos_nxt;
    dup_r             <= dup_nxt;
    j_r               <= j_nxt;
    k_r               <= k_nxt;
    runs_r            <= runs_nxt;
    edata_r           <= edata_nxt;
    out_end_point_r   <= out_end_point_nxt;
    out_end_valid_r   <= out_end_valid_nxt;
    out_start_point_r <= out_start_point_nxt;
    out_start_valid_r <= out_start_valid_nxt;
    out_overflow_r    <= out_overflow_nxt;
    out_last_r        <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_end_point   = out_end_point_r;
  assign out_end_valid   = out_end_valid_r;
  assign out_start_point = out_start_point_r;
  assign out_start_valid = out_start_valid_r;
  assign out_overflow    = out_overflow_r;
  assign out_last_result = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_OUT_EMIT)
    else $error("result strobe without an emit step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (end_cnt_r <= DEPTH_C) && (start_cnt_r <= DEPTH_C) && (pairs_r <= DEPTH_C))
    else $error("list count beyond capacity");

  a_cleared_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |->
      (end_cnt_r == '0) && (start_cnt_r == '0) && (pairs_r == '0) && !ovf_r)
    else $error("set state not cleared after the last result");

  a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> !busy || $past(state_r) != S_OUT_EMIT)
    else $error("sequencer still busy after the last result");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for window_filter_sort_dedup. Sets of point pairs run
// through a window, a sorted-insert and a de-duplication step inside the
// bench's own copy of both lists; each strobed readout entry is checked field
// by field against the oldest predicted entry. Directed sets cover the
// extremes, empty and unequal lists and inverted windows. Random sets cover
// several window settings and overflowing sets.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfsd_pkg::*;

  localparam int DEPTH         = 32;
  localparam int SETTLE_CYCLES = 12;      // settle time after each drain
  localparam int TAIL_CYCLES   = 150;     // longer than a full 32-entry readout
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int IDLE_PCT      = 16;
  localparam int PHASE_ITEMS   = 36;

  typedef struct {
    point_t right;
    point_t left;
    logic   last;
  } pair_t;

  typedef struct {
    point_t end_point;
    logic   end_valid;
    point_t start_point;
    logic   start_valid;
    logic   overflow;
    logic   last_result;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_START;
  point_t               cfg_wdata = '0;

  logic   start = 1'b0;
  logic   busy;
  point_t in_right_point = '0;
  point_t in_left_point = '0;
  logic   in_last_pair = 1'b0;

  logic   out_valid;
  point_t out_end_point;
  logic   out_end_valid;
  point_t out_start_point;
  logic   out_start_valid;
  logic   out_overflow;
  logic   out_last_result;

  window_filter_sort_dedup #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_right_point  (in_right_point),
    .in_left_point   (in_left_point),
    .in_last_pair    (in_last_pair),
    .out_valid       (out_valid),
    .out_end_point   (out_end_point),
    .out_end_valid   (out_end_valid),
    .out_start_point (out_start_point),
    .out_start_valid (out_start_valid),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the block: window, both lists and the set bookkeeping.
  // --------------------------------------------------------------------------
  point_t   win_lo = WINDOW_START_RST;
  point_t   win_hi = WINDOW_END_RST;
  point_t   lists [2][DEPTH];     // indexed by LIST_END / LIST_START
  int       list_len [2] = '{0, 0};
  int       pairs_in_set = 0;
  bit       set_overflow = 1'b0;

  pair_t    pair_q[$];            // pairs waiting for the driver
  readout_t readout_q[$];         // predicted readout entries, oldest first
  point_t   recent_pts[$];        // recently used points, to provoke repeats

  int       errors = 0;
  int       cycles = 0;
  bit       steady = 1'b0;        // hold start off idling for a whole phase

  // Insert v in order; the end list ascends, the start list descends.
  // Drop v if it is already present.
  function automatic void insert_sorted(logic which, point_t v);
    int pos;
    int n;
    pos = 0;
    n = list_len[which];
    while (pos < n) begin
      if (lists[which][pos] == v) return;
      if (which == LIST_END ? lists[which][pos] > v : lists[which][pos] < v) break;
      pos++;
    end
    if (n >= DEPTH) return;
    for (int k = n; k > pos; k--) lists[which][k] = lists[which][k-1];
    lists[which][pos] = v;
    list_len[which] = n + 1;
  endfunction

  // Fold one transferred pair into the set; on the last pair, queue the
  // side-by-side readout and clear the set.
  function automatic void take_pair(pair_t p);
    readout_t r;
    int runs;
    if (pairs_in_set >= DEPTH) begin
      set_overflow = 1'b1;
    end else begin
      pairs_in_set++;
      if (p.right >= win_lo && p.right <= win_hi) insert_sorted(LIST_END, p.right);
      if (p.left >= win_lo && p.left <= win_hi) insert_sorted(LIST_START, p.left);
    end
    if (!p.last) return;

    runs = list_len[LIST_END] > list_len[LIST_START] ? list_len[LIST_END]
                                                      : list_len[LIST_START];
    if (runs == 0) runs = 1;
    for (int k = 0; k < runs; k++) begin
      r.end_valid   = k < list_len[LIST_END];
      r.end_point   = r.end_valid ? lists[LIST_END][k] : '0;
      r.start_valid = k < list_len[LIST_START];
      r.start_point = r.start_valid ? lists[LIST_START][k] : '0;
      r.overflow    = set_overflow;
      r.last_result = (k == runs - 1);
      readout_q.push_back(r);
    end
    list_len[LIST_END]   = 0;
    list_len[LIST_START] = 0;
    pairs_in_set         = 0;
    set_overflow         = 1'b0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next pair from pair_q, hold it until the transfer.
  // start changes at most once per edge; back-to-back pairs keep it high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pair_t p;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        p.right = in_right_point;
        p.left  = in_left_point;
        p.last  = in_last_pair;
        take_pair(p);
      end
      // slot is free when nothing is offered or the offer just transferred
      if (!start || !busy) begin
        if (pair_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          p = pair_q.pop_front();
          in_right_point <= p.right;
          in_left_point  <= p.left;
          in_last_pair   <= p.last;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobe is one readout entry; compare with the oldest one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    readout_t want;
    if (rst_n && out_valid) begin
      if (readout_q.size() == 0) begin
        report_mismatch("unexpected result, end_point", out_end_point, 0);
      end else begin
        want = readout_q.pop_front();
        if (out_end_valid !== want.end_valid)
          report_mismatch("end_valid", out_end_valid, want.end_valid);
        if (out_end_point !== want.end_point)
          report_mismatch("end_point", out_end_point, want.end_point);
        if (out_start_valid !== want.start_valid)
          report_mismatch("start_valid", out_start_valid, want.start_valid);
        if (out_start_point !== want.start_point)
          report_mismatch("start_point", out_start_point, want.start_point);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
        if (out_last_result !== want.last_result)
          report_mismatch("last_result", out_last_result, want.last_result);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_pair(point_t right, point_t left, logic last);
    pair_t p;
    p.right = right;
    p.left  = left;
    p.last  = last;
    pair_q.push_back(p);
  endfunction

  // Mix of in-window values, window edges, repeats and raw 16-bit values.
  function automatic point_t pick_point();
    int unsigned sel;
    point_t v;
    sel = $urandom_range(99);
    if (sel < 40 && win_lo <= win_hi)
      v = point_t'($urandom_range(win_hi, win_lo));
    else if (sel < 55)
      case ($urandom_range(3))
        0:       v = win_lo;
        1:       v = win_hi;
        2:       v = win_lo - 1'b1;
        default: v = win_hi + 1'b1;
      endcase
    else if (sel < 70 && recent_pts.size() != 0)
      v = recent_pts[$urandom_range(recent_pts.size() - 1)];
    else
      v = point_t'($urandom);
    recent_pts.push_back(v);
    if (recent_pts.size() > 16) void'(recent_pts.pop_front());
    return v;
  endfunction

  function automatic void queue_set(int len);
    for (int i = 0; i < len; i++) push_pair(pick_point(), pick_point(), i == len - 1);
  endfunction

  // Write both window registers; the block is idle whenever this runs.
  task automatic write_window(point_t lo, point_t hi);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_START;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_WINDOW_END;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  // Wait until every pair has transferred and every readout entry arrived,
  // then give the sequencer time to return to idle.
  task automatic drain();
    while (pair_q.size() != 0 || start || busy || readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    point_t lo;
    int     items;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window [0, 65535]: field extremes, duplicates, a single-pair set.
    push_pair(16'h0000, 16'hFFFF, 1'b0);
    push_pair(16'hFFFF, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'h0000, 1'b0);     // repeat on both lists
    push_pair(16'h5555, 16'hAAAA, 1'b0);
    push_pair(16'h0001, 16'hFFFE, 1'b1);
    push_pair(16'h0005, 16'h0005, 1'b1);     // one pair, one entry each
    drain();

    // Narrow window: nothing kept gives one empty entry; unequal list lengths.
    write_window(16'd100, 16'd200);
    push_pair(16'd99, 16'd201, 1'b0);
    push_pair(16'd201, 16'd99, 1'b1);
    push_pair(16'd100, 16'd200, 1'b0);
    push_pair(16'd200, 16'd100, 1'b0);
    push_pair(16'd150, 16'd150, 1'b0);
    push_pair(16'd300, 16'd120, 1'b0);       // left only
    push_pair(16'd250, 16'd130, 1'b0);       // left only
    push_pair(16'd150, 16'd0, 1'b1);         // right repeat, left out
    push_pair(16'd180, 16'd999, 1'b0);       // right only
    push_pair(16'd110, 16'hFFFF, 1'b1);
    drain();

    // Inverted window keeps nothing at all.
    write_window(16'd200, 16'd100);
    push_pair(16'd150, 16'd150, 1'b0);
    push_pair(16'd100, 16'd200, 1'b0);
    push_pair(16'd200, 16'd100, 1'b1);
    drain();

    // Full window: a set of exactly DEPTH pairs, one whose marked last
    // pair is dropped, and one that overflows well past the depth.
    write_window(16'h0000, 16'hFFFF);
    queue_set(DEPTH);
    queue_set(DEPTH + 1);
    queue_set(DEPTH + 7);
    drain();

    // Random phases over several windows, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_window(16'h0000, 16'hFFFF);
        1: begin
          lo = point_t'($urandom);
          write_window(lo, (lo > 16'hF82F) ? 16'hFFFF : lo + point_t'($urandom_range(2000)));
        end
        2: write_window(16'hFFFF, 16'hFFFF);
        3: begin
          lo = point_t'($urandom_range(65535, 1));
          write_window(lo, point_t'($urandom_range(lo - 1)));
        end
        4: write_window(point_t'($urandom_range(16383)),
                        point_t'($urandom_range(65535, 49152)));
        default: write_window(16'h0000, 16'h0000);
      endcase
      steady = (phase == 2);
      items = 0;
      while (items < PHASE_ITEMS) begin
        // mostly short sets; now and then one near or past the depth
        if ($urandom_range(99) < 8) begin
          queue_set($urandom_range(DEPTH + 8, DEPTH - 2));
        end else begin
          queue_set($urandom_range(10, 1));
        end
        items = pair_q.size() + items;
        drain();
      end
      steady = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
